[rtl/core/sva_pkg.sv]
package sva_pkg;

    // Default sizing of the voice table.
    localparam int VOICES_DEFAULT        = 8;
    localparam int POSITION_BITS_DEFAULT = 24;

    // Fixed field widths of the stream words.
    localparam int SAMPLE_ID_BITS   = 16;
    localparam int LENGTH_BITS      = 24;
    localparam int GAIN_BITS        = 16;
    localparam int AGE_BITS         = 32;
    localparam int OUT_INDEX_BITS   = 3;
    localparam int OUT_POS_BITS     = 24;

    // Input word: sample_ref, sample_valid, frame_count, gain_left, gain_right.
    localparam int IN_FIELD_BITS  = SAMPLE_ID_BITS + 1 + LENGTH_BITS + 2 * GAIN_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;

    // Output word: voice_slot, stolen, voice_sample, frame_position, gains.
    localparam int OUT_FIELD_BITS = OUT_INDEX_BITS + 1 + SAMPLE_ID_BITS + OUT_POS_BITS
                                    + 2 * GAIN_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int KIND_BITS = 2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_REJECTED = 2'd1,
        KIND_VOICE    = 2'd2,
        KIND_SILENT   = 2'd3
    } kind_t;

    // Command carried in the input tuser bit.
    localparam logic CMD_TRIGGER = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

endpackage

[rtl/core/sampler_voice_allocator_top.sv]
// Sampler voice allocator. The block holds a table of VOICES sampler voices and
// takes two kinds of input word, selected by s_axis_tuser. A trigger (tuser 0)
// with a valid sample of nonzero length claims the lowest free voice, or, when
// every voice is busy, steals the voice with the smallest age stamp (lowest
// index on a tie); it answers with one accepted word, or one rejected word with
// all other fields zero. A frame tick (tuser 1) answers with one word per active
// voice in index order, giving the frame position to fetch, then advances that
// position and loops it to zero at the sample length; with no active voice it
// answers with one silent word. The final word caused by an input carries tlast.
// Sequencing: the block works on one input word at a time and is not ready while
// it does so. A single shared magnitude comparator, driven by a small sequencer,
// does all age and position comparisons, one voice at a time. A rejected trigger
// is accepted and then answered; an accepted trigger scans the voices from index
// 0 up to the first free one, or the whole table, and then writes its voice. A
// frame tick passes idle voices and, for each active voice, reads and compares,
// emits and writes back; voices above the last active one are skipped. With no
// active voice it walks the whole table and then emits the silent word. A stall
// on the output side holds the sequencer in the state that emits the word.
// The result register is separate from the sequencer, so a finished word may wait
// for the downstream side while the next input word is taken. No clearing pass is
// needed after reset: the voice table is left as is; the active bits are reset.
module sampler_voice_allocator_top #(
    parameter int VOICES        = sva_pkg::VOICES_DEFAULT,
    parameter int POSITION_BITS = sva_pkg::POSITION_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input word, tdata from bit 0 up: sample_ref[15:0], sample_valid,
    // frame_count[23:0], gain_left[15:0], gain_right[15:0], zero padding.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sva_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // Input tuser: cmd (0 trigger, 1 frame tick).
    input  logic                               s_axis_tuser,
    // Output word, tdata from bit 0 up: voice_slot[2:0], stolen,
    // voice_sample[15:0], frame_position[23:0], out_gain_left[15:0],
    // out_gain_right[15:0], zero padding.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [sva_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
    // Output tuser: kind[1:0].
    output logic [sva_pkg::KIND_BITS-1:0]      m_axis_tuser,
    output logic                               m_axis_tlast
);

    import sva_pkg::*;

    localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int PB    = POSITION_BITS;
    localparam int CMP_W = (PB > AGE_BITS) ? PB : AGE_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICES - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REJECT,
        S_FIND,
        S_WRITE,
        S_TICK_RD,
        S_TICK_EMIT,
        S_TICK_WB,
        S_SILENT
    } state_t;

    // Sequencer and working registers.
    state_t                     state_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [IDX_W-1:0]           target_reg;
    logic                       stolen_reg;
    logic                       seen_reg;
    logic [AGE_BITS-1:0]        min_reg;
    logic [PB-1:0]              pos_reg;
    logic [AGE_BITS-1:0]        age_reg;
    logic [VOICES-1:0]          active_reg;

    // Latched trigger fields.
    logic [SAMPLE_ID_BITS-1:0]  trig_sample_reg;
    logic [LENGTH_BITS-1:0]     trig_len_reg;
    logic [GAIN_BITS-1:0]       trig_gl_reg;
    logic [GAIN_BITS-1:0]       trig_gr_reg;

    // Voice table; every entry is read only at the sequencer's index.
    logic [SAMPLE_ID_BITS-1:0]  smp_tab [VOICES];
    logic [PB-1:0]              pos_tab [VOICES];
    logic [LENGTH_BITS-1:0]     len_tab [VOICES];
    logic [GAIN_BITS-1:0]       gl_tab  [VOICES];
    logic [GAIN_BITS-1:0]       gr_tab  [VOICES];
    logic [AGE_BITS-1:0]        age_tab [VOICES];

    // Result register.
    logic                       out_valid_reg;
    kind_t                      out_kind_reg;
    logic [OUT_INDEX_BITS-1:0]  out_idx_reg;
    logic                       out_stolen_reg;
    logic [SAMPLE_ID_BITS-1:0]  out_sample_reg;
    logic [OUT_POS_BITS-1:0]    out_pos_reg;
    logic [GAIN_BITS-1:0]       out_gl_reg;
    logic [GAIN_BITS-1:0]       out_gr_reg;
    logic                       out_last_reg;

    // Input field unpacking.
    logic                       in_cmd;
    logic [SAMPLE_ID_BITS-1:0]  in_sample;
    logic                       in_sample_valid;
    logic [LENGTH_BITS-1:0]     in_len;
    logic [GAIN_BITS-1:0]       in_gl;
    logic [GAIN_BITS-1:0]       in_gr;

    assign in_cmd          = s_axis_tuser;
    assign in_sample       = s_axis_tdata[15:0];
    assign in_sample_valid = s_axis_tdata[16];
    assign in_len          = s_axis_tdata[40:17];
    assign in_gl           = s_axis_tdata[56:41];
    assign in_gr           = s_axis_tdata[72:57];

    logic in_accept;
    logic out_free;
    logic out_load;
    logic idx_last;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign idx_last      = (idx_reg == LAST_IDX);

    // A new result word is loaded in this cycle.
    assign out_load = out_free
                      && (state_reg inside {S_REJECT, S_WRITE, S_TICK_EMIT, S_SILENT});

    // The shared comparator. Ages are compared during the free-voice scan and
    // positions against lengths during a frame tick.
    logic [CMP_W-1:0] cmp_a;
    logic [CMP_W-1:0] cmp_b;
    logic             cmp_lt;

    always_comb
    begin
        case (state_reg)
            S_FIND:
            begin
                cmp_a = CMP_W'(age_tab[idx_reg]);
                cmp_b = CMP_W'(min_reg);
            end
            S_TICK_RD:
            begin
                cmp_a = CMP_W'(pos_tab[idx_reg]);
                cmp_b = CMP_W'(len_tab[idx_reg]);
            end
            S_TICK_WB:
            begin
                cmp_a = CMP_W'(pos_reg);
                cmp_b = CMP_W'(len_tab[idx_reg]);
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_lt = (cmp_a < cmp_b);

    // Whether any voice above the current index is active decides tlast.
    logic later_active;

    always_comb
    begin
        later_active = 1'b0;
        for (int i = 0; i < VOICES; i++)
        begin
            if ((i > int'(idx_reg)) && active_reg[i])
            begin
                later_active = 1'b1;
            end
        end
    end

    // Width adaption of the index and position to the result fields.
    logic [IDX_W+OUT_INDEX_BITS-1:0] idx_wide;
    logic [IDX_W+OUT_INDEX_BITS-1:0] target_wide;
    logic [PB+OUT_POS_BITS-1:0]      pos_wide;

    assign idx_wide    = {{OUT_INDEX_BITS{1'b0}}, idx_reg};
    assign target_wide = {{OUT_INDEX_BITS{1'b0}}, target_reg};
    assign pos_wide    = {{OUT_POS_BITS{1'b0}}, pos_reg};

    logic [AGE_BITS-1:0] age_inc;

    assign age_inc = age_reg + AGE_BITS'(1);

    logic wr_trigger;
    logic wr_position;

    assign wr_trigger  = (state_reg == S_WRITE) && out_free;
    assign wr_position = (state_reg == S_TICK_WB);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            target_reg      <= '0;
            stolen_reg      <= 1'b0;
            seen_reg        <= 1'b0;
            min_reg         <= '0;
            pos_reg         <= '0;
            age_reg         <= AGE_BITS'(1);
            active_reg      <= '0;
            trig_sample_reg <= '0;
            trig_len_reg    <= '0;
            trig_gl_reg     <= '0;
            trig_gr_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= KIND_ACCEPTED;
            out_idx_reg     <= '0;
            out_stolen_reg  <= 1'b0;
            out_sample_reg  <= '0;
            out_pos_reg     <= '0;
            out_gl_reg      <= '0;
            out_gr_reg      <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        idx_reg         <= '0;
                        seen_reg        <= 1'b0;
                        trig_sample_reg <= in_sample;
                        trig_len_reg    <= in_len;
                        trig_gl_reg     <= in_gl;
                        trig_gr_reg     <= in_gr;
                        if (in_cmd == CMD_TICK)
                        begin
                            state_reg <= S_TICK_RD;
                        end
                        else if (!in_sample_valid || (in_len == '0))
                        begin
                            state_reg <= S_REJECT;
                        end
                        else
                        begin
                            state_reg <= S_FIND;
                        end
                    end
                end

                S_REJECT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= KIND_REJECTED;
                        out_idx_reg    <= '0;
                        out_stolen_reg <= 1'b0;
                        out_sample_reg <= '0;
                        out_pos_reg    <= '0;
                        out_gl_reg     <= '0;
                        out_gr_reg     <= '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                S_FIND:
                begin
                    // The first free voice wins outright; otherwise keep the
                    // strictly smallest stamp so that ties go to the lower index.
                    if (!active_reg[idx_reg])
                    begin
                        target_reg <= idx_reg;
                        stolen_reg <= 1'b0;
                        state_reg  <= S_WRITE;
                    end
                    else
                    begin
                        if ((idx_reg == '0) || cmp_lt)
                        begin
                            min_reg    <= age_tab[idx_reg];
                            target_reg <= idx_reg;
                        end
                        if (idx_last)
                        begin
                            stolen_reg <= 1'b1;
                            state_reg  <= S_WRITE;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + IDX_W'(1);
                        end
                    end
                end

                S_WRITE:
                begin
                    if (out_free)
                    begin
                        active_reg[target_reg] <= 1'b1;
                        age_reg        <= (age_inc == '0) ? AGE_BITS'(1) : age_inc;
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= KIND_ACCEPTED;
                        out_idx_reg    <= target_wide[OUT_INDEX_BITS-1:0];
                        out_stolen_reg <= stolen_reg;
                        out_sample_reg <= trig_sample_reg;
                        out_pos_reg    <= '0;
                        out_gl_reg     <= trig_gl_reg;
                        out_gr_reg     <= trig_gr_reg;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                S_TICK_RD:
                begin
                    if (active_reg[idx_reg])
                    begin
                        // A stored position at or beyond the length restarts at 0.
                        pos_reg   <= cmp_lt ? pos_tab[idx_reg] : '0;
                        seen_reg  <= 1'b1;
                        state_reg <= S_TICK_EMIT;
                    end
                    else if (idx_last)
                    begin
                        state_reg <= seen_reg ? S_IDLE : S_SILENT;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IDX_W'(1);
                    end
                end

                S_TICK_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= KIND_VOICE;
                        out_idx_reg    <= idx_wide[OUT_INDEX_BITS-1:0];
                        out_stolen_reg <= 1'b0;
                        out_sample_reg <= smp_tab[idx_reg];
                        out_pos_reg    <= pos_wide[OUT_POS_BITS-1:0];
                        out_gl_reg     <= gl_tab[idx_reg];
                        out_gr_reg     <= gr_tab[idx_reg];
                        out_last_reg   <= !later_active;
                        pos_reg        <= pos_reg + PB'(1);
                        state_reg      <= S_TICK_WB;
                    end
                end

                S_TICK_WB:
                begin
                    if (idx_last || !later_active)
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_TICK_RD;
                    end
                end

                S_SILENT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_kind_reg   <= KIND_SILENT;
                        out_idx_reg    <= '0;
                        out_stolen_reg <= 1'b0;
                        out_sample_reg <= '0;
                        out_pos_reg    <= '0;
                        out_gl_reg     <= '0;
                        out_gr_reg     <= '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Voice table contents; only meaningful while the entry is active.
    always_ff @(posedge clk)
    begin
        if (wr_trigger)
        begin
            smp_tab[target_reg] <= trig_sample_reg;
            pos_tab[target_reg] <= '0;
            len_tab[target_reg] <= trig_len_reg;
            gl_tab[target_reg]  <= trig_gl_reg;
            gr_tab[target_reg]  <= trig_gr_reg;
            age_tab[target_reg] <= age_reg;
        end
        else if (wr_position)
        begin
            pos_tab[idx_reg] <= cmp_lt ? pos_reg : '0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}},
                            out_gr_reg, out_gl_reg, out_pos_reg, out_sample_reg,
                            out_stolen_reg, out_idx_reg};

    // The age counter skips zero, so a stamp is never zero.
    a_age_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        age_reg != '0)
        else $error("age counter reached zero");

    // Trigger and silent words always close their input word.
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_kind_reg != KIND_VOICE)) |-> out_last_reg)
        else $error("single result word without tlast");

    // Only an accepted trigger can report a stolen voice.
    a_stolen_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stolen_reg) |-> (out_kind_reg == KIND_ACCEPTED))
        else $error("stolen flag on a word that is not an accepted trigger");

    // A stolen voice is only taken when the whole table is busy.
    a_steal_full: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_trigger && stolen_reg) |-> (&active_reg))
        else $error("voice stolen while a free voice existed");

    // Once a word is taken, the sequencer is busy in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> !s_axis_tready)
        else $error("ready stayed high after an input word");

endmodule
